@@ hdl/bsp_pkg.sv @@
// billboard sprite projection: shared beat types, register codes and widths
// no dependencies; imported by bsp_front, bsp_back, the top level and the testbench
package bsp_pkg;

  localparam int QW = 25;
  localparam int FRONT_STAGES = 4;
  localparam int BACK_STAGES = 2;
  localparam int NST = FRONT_STAGES + QW + 1 + BACK_STAGES;

  localparam int CFG_W = 13;
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_WIDTH = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_SCREEN_HEIGHT = 2'd1;
  localparam logic [CFG_W-1:0] SCREEN_WIDTH_RST = 13'd640;
  localparam logic [CFG_W-1:0] SCREEN_HEIGHT_RST = 13'd480;

  localparam int ND_W = 52;
  localparam int DD_W = 33;
  localparam int NC_W = 47;
  localparam int DC_W = 34;
  localparam int NF_W = 46;
  localparam int DF_W = 40;

  typedef struct packed {
    logic signed [15:0] sprite_pos_x;
    logic signed [15:0] sprite_pos_y;
    logic [11:0]        sprite_scale;
    logic signed [15:0] viewer_x;
    logic signed [15:0] viewer_y;
    logic signed [15:0] look_x;
    logic signed [15:0] look_y;
    logic signed [15:0] view_plane_x;
    logic signed [15:0] view_plane_y;
  } bsp_in_t;

  typedef struct packed {
    logic               in_front;
    logic signed [23:0] depth;
    logic signed [15:0] center_column;
    logic [14:0]        scaled_height;
    logic [14:0]        scaled_width;
    logic [14:0]        first_column;
    logic signed [15:0] end_column;
    logic [14:0]        first_row;
    logic [11:0]        end_row;
  } bsp_out_t;

  typedef struct packed {
    logic        neg_d;
    logic        neg_c;
    logic        det_nz;
    logic [11:0] scale;
  } bsp_side_t;

  typedef struct packed {
    logic [ND_W-1:0] num_d;
    logic [DD_W-1:0] den_d;
    logic [NC_W-1:0] num_c;
    logic [DC_W-1:0] den_c;
    logic [NF_W-1:0] num_f;
    logic [DF_W-1:0] den_f;
    bsp_side_t       side;
  } bsp_fe_t;

  typedef struct packed {
    logic [QW-1:0] quo_d;
    logic          ovf_d;
    logic [QW-1:0] quo_c;
    logic          ovf_c;
    logic [QW-1:0] quo_f;
  } bsp_quo_t;

endpackage

@@ hdl/bsp_div.sv @@
// pipelined restoring divider on unsigned values, one quotient bit per stage
// depends on nothing; used three times by the top level
module bsp_div #(
  parameter int NW = 52,
  parameter int DW = 33,
  parameter int QB = 25
) (
  input  logic          clk,
  input  logic          en,
  input  logic [NW-1:0] num,
  input  logic [DW-1:0] den,
  output logic [QB-1:0] quo,
  output logic          ovf
);

  localparam int CW = (NW > DW + QB) ? NW : DW + QB;

  logic [CW-1:0] r_r [0:QB-1];
  logic [DW-1:0] d_r [0:QB-1];
  logic [QB-1:0] q_r [0:QB];
  logic          o_r [0:QB];

  always_ff @(posedge clk) begin
    if (en) begin
      r_r[0] <= CW'(num);
      d_r[0] <= den;
      q_r[0] <= '0;
      o_r[0] <= CW'(num) >= (CW'(den) << QB);
    end
  end

  for (genvar k = 1; k <= QB; k++) begin : g_stage
    logic [CW-1:0] sh;
    logic          ge;
    logic [QB-1:0] q_nxt;
    assign sh = CW'(d_r[k-1]) << (QB - k);
    assign ge = r_r[k-1] >= sh;
    always_comb begin
      q_nxt = q_r[k-1];
      q_nxt[QB-k] = ge;
    end
    always_ff @(posedge clk) begin
      if (en) begin
        q_r[k] <= q_nxt;
        o_r[k] <= o_r[k-1];
      end
    end
    if (k < QB) begin : g_rem
      always_ff @(posedge clk) begin
        if (en) begin
          r_r[k] <= ge ? r_r[k-1] - sh : r_r[k-1];
          d_r[k] <= d_r[k-1];
        end
      end
    end
  end

  assign quo = q_r[QB];
  assign ovf = o_r[QB];

endmodule

@@ hdl/bsp_front.sv @@
// camera transform: offsets, products, det/tx/ty and divider operands
// four register stages; uses bsp_pkg
module bsp_front (
  input  logic                        clk,
  input  logic                        en,
  input  logic [bsp_pkg::CFG_W-1:0]   scr_w,
  input  logic [bsp_pkg::CFG_W-1:0]   scr_h,
  input  bsp_pkg::bsp_in_t            in_beat,
  output bsp_pkg::bsp_fe_t            fe
);
  import bsp_pkg::*;

  // stage 1
  logic signed [16:0] dx_r, dy_r;
  logic signed [31:0] pd1_r, pd2_r;
  logic signed [15:0] lx_r, ly_r, qx_r, qy_r;
  logic [11:0]        sc1_r;
  // stage 2
  logic signed [32:0] m_lydx_r, m_lxdy_r, m_qxdy_r, m_qydx_r, det_r;
  logic [11:0]        sc2_r;
  // stage 3
  logic signed [33:0] tx_nxt, ty_nxt;
  logic signed [34:0] c_nxt;
  logic [32:0]        mdet_r;
  logic [33:0]        mty_r;
  logic [34:0]        mc_r;
  bsp_side_t          side3_r;
  // stage 4
  bsp_fe_t            fe_r;

  always_ff @(posedge clk) begin
    if (en) begin
      dx_r  <= {in_beat.sprite_pos_x[15], in_beat.sprite_pos_x}
             - {in_beat.viewer_x[15], in_beat.viewer_x};
      dy_r  <= {in_beat.viewer_y[15], in_beat.viewer_y}
             - {in_beat.sprite_pos_y[15], in_beat.sprite_pos_y};
      pd1_r <= in_beat.view_plane_x * in_beat.look_y;
      pd2_r <= in_beat.look_x * in_beat.view_plane_y;
      lx_r  <= in_beat.look_x;
      ly_r  <= in_beat.look_y;
      qx_r  <= in_beat.view_plane_x;
      qy_r  <= in_beat.view_plane_y;
      sc1_r <= in_beat.sprite_scale;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      m_lydx_r <= ly_r * dx_r;
      m_lxdy_r <= lx_r * dy_r;
      m_qxdy_r <= qx_r * dy_r;
      m_qydx_r <= qy_r * dx_r;
      det_r    <= pd1_r - pd2_r;
      sc2_r    <= sc1_r;
    end
  end

  assign tx_nxt = m_lydx_r - m_lxdy_r;
  assign ty_nxt = m_qxdy_r - m_qydx_r;
  assign c_nxt  = ty_nxt - tx_nxt;

  always_ff @(posedge clk) begin
    if (en) begin
      mdet_r <= det_r[32] ? 33'(-det_r) : 33'(det_r);
      mty_r  <= ty_nxt[33] ? 34'(-ty_nxt) : 34'(ty_nxt);
      mc_r   <= c_nxt[34] ? 35'(-c_nxt) : 35'(c_nxt);
      side3_r.neg_d  <= ty_nxt[33] ^ det_r[32];
      side3_r.neg_c  <= c_nxt[34] ^ ty_nxt[33];
      side3_r.det_nz <= det_r != '0;
      side3_r.scale  <= sc2_r;
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      fe_r.num_d <= {mty_r, 18'd0};
      fe_r.den_d <= mdet_r;
      fe_r.num_c <= NC_W'(scr_w[CFG_W-1:1]) * NC_W'(mc_r);
      fe_r.den_c <= mty_r;
      fe_r.num_f <= NF_W'(scr_h) * NF_W'(mdet_r);
      fe_r.den_f <= {mty_r, 6'd0};
      fe_r.side  <= side3_r;
    end
  end

  assign fe = fe_r;

endmodule

@@ hdl/bsp_back.sv @@
// quotient cleanup, saturation, size and clamped draw rectangle
// two register stages, the second is the output register; uses bsp_pkg
module bsp_back (
  input  logic                      clk,
  input  logic                      en,
  input  logic [bsp_pkg::CFG_W-1:0] scr_w,
  input  logic [bsp_pkg::CFG_W-1:0] scr_h,
  input  bsp_pkg::bsp_quo_t         quo,
  input  bsp_pkg::bsp_side_t        side,
  output bsp_pkg::bsp_out_t         res
);
  import bsp_pkg::*;

  logic signed [23:0] depth_nxt, depth_r;
  logic signed [15:0] center_nxt, center_r;
  logic               front_nxt, front_r;
  logic [QW-1:0]      full_r;
  logic [36:0]        prod_r;

  logic signed [31:0] size_s, half_s, bottom_s, top_s, left_s, right_s, cen_s;
  logic signed [31:0] h_s, w_s;
  bsp_out_t           res_nxt, res_r;

  always_comb begin
    if (!side.det_nz) begin
      depth_nxt = '0;
    end else if (quo.ovf_d || quo.quo_d[QW-1:23] != '0) begin
      depth_nxt = side.neg_d ? 24'sh800000 : 24'sh7FFFFF;
    end else if (side.neg_d) begin
      depth_nxt = -$signed({1'b0, quo.quo_d[22:0]});
    end else begin
      depth_nxt = $signed({1'b0, quo.quo_d[22:0]});
    end
    front_nxt = side.det_nz && !side.neg_d && (quo.ovf_d || quo.quo_d != '0);
    if (side.neg_c) begin
      if (quo.ovf_c || quo.quo_c > QW'(32768)) begin
        center_nxt = 16'sh8000;
      end else begin
        center_nxt = 16'(-$signed({1'b0, quo.quo_c[16:0]}));
      end
    end else begin
      if (quo.ovf_c || quo.quo_c > QW'(32767)) begin
        center_nxt = 16'sh7FFF;
      end else begin
        center_nxt = $signed({1'b0, quo.quo_c[14:0]});
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      depth_r  <= depth_nxt;
      center_r <= center_nxt;
      front_r  <= front_nxt;
      full_r   <= quo.quo_f;
      prod_r   <= quo.quo_f * side.scale;
    end
  end

  always_comb begin
    h_s      = $signed({19'd0, scr_h});
    w_s      = $signed({19'd0, scr_w});
    cen_s    = 32'(center_r);
    size_s   = $signed({3'd0, prod_r[36:8]});
    half_s   = size_s >>> 1;
    bottom_s = $signed({20'd0, scr_h[CFG_W-1:1]}) + $signed({8'd0, full_r[QW-1:1]});
    top_s    = bottom_s - size_s;
    left_s   = cen_s - half_s;
    right_s  = cen_s + half_s;
    if (top_s < 0) top_s = '0;
    if (bottom_s >= h_s) bottom_s = h_s - 32'sd1;
    if (left_s < 0) left_s = '0;
    if (right_s >= w_s) right_s = w_s - 32'sd1;

    res_nxt       = '0;
    res_nxt.depth = depth_r;
    if (front_r) begin
      res_nxt.in_front      = 1'b1;
      res_nxt.center_column = center_r;
      res_nxt.scaled_height = (size_s > 32'sd32767) ? 15'h7FFF : size_s[14:0];
      res_nxt.scaled_width  = res_nxt.scaled_height;
      res_nxt.first_column  = (left_s > 32'sd32767) ? 15'h7FFF : left_s[14:0];
      res_nxt.end_column    = (right_s > 32'sd32767) ? 16'sh7FFF : right_s[15:0];
      res_nxt.first_row     = (top_s > 32'sd32767) ? 15'h7FFF : top_s[14:0];
      if (bottom_s < 0) begin
        res_nxt.end_row = '0;
      end else if (bottom_s > 32'sd4095) begin
        res_nxt.end_row = 12'hFFF;
      end else begin
        res_nxt.end_row = bottom_s[11:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (en) begin
      res_r <= res_nxt;
    end
  end

  assign res = res_r;

endmodule

@@ hdl/billboard_sprite_projection_unit.sv @@
// top level of the billboard sprite projection block
// uses bsp_pkg, bsp_front, bsp_div and bsp_back
// One sprite beat enters per cycle unless the pipeline is held, and passes through four
// transform stages, three 25-stage restoring dividers working side by side
// (plus an operand stage) and two stages of saturation and rectangle clamping.
// The pipeline holds as a whole while a waiting result is stalled. Screen size
// registers are read live and are to be changed only with the pipeline empty.
module billboard_sprite_projection_unit (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  bsp_pkg::bsp_in_t              in_data,
  output logic                          out_valid,
  input  logic                          out_stall,
  output bsp_pkg::bsp_out_t             out_data,
  input  logic                          cfg_we,
  input  logic [bsp_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [bsp_pkg::CFG_W-1:0]     cfg_data
);
  import bsp_pkg::*;

  logic [CFG_W-1:0] scr_w_r, scr_h_r;
  logic [NST-1:0]   v_r;
  logic             en;
  bsp_fe_t          fe;
  bsp_quo_t         quo;
  bsp_side_t        side_r [0:QW];

  assign en       = !(v_r[NST-1] && out_stall);
  assign in_stall = !en;
  assign out_valid = v_r[NST-1];

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scr_w_r <= SCREEN_WIDTH_RST;
      scr_h_r <= SCREEN_HEIGHT_RST;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_SCREEN_WIDTH:  scr_w_r <= cfg_data;
        REG_SCREEN_HEIGHT: scr_h_r <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else if (en) begin
      v_r <= {v_r[NST-2:0], in_valid};
    end
  end

  bsp_front u_front (
    .clk     (clk),
    .en      (en),
    .scr_w   (scr_w_r),
    .scr_h   (scr_h_r),
    .in_beat (in_data),
    .fe      (fe)
  );

  bsp_div #(.NW(ND_W), .DW(DD_W), .QB(QW)) u_div_depth (
    .clk (clk), .en (en), .num (fe.num_d), .den (fe.den_d),
    .quo (quo.quo_d), .ovf (quo.ovf_d)
  );

  bsp_div #(.NW(NC_W), .DW(DC_W), .QB(QW)) u_div_center (
    .clk (clk), .en (en), .num (fe.num_c), .den (fe.den_c),
    .quo (quo.quo_c), .ovf (quo.ovf_c)
  );

  logic ovf_f_unused;
  bsp_div #(.NW(NF_W), .DW(DF_W), .QB(QW)) u_div_full (
    .clk (clk), .en (en), .num (fe.num_f), .den (fe.den_f),
    .quo (quo.quo_f), .ovf (ovf_f_unused)
  );

  always_ff @(posedge clk) begin
    if (en) begin
      side_r[0] <= fe.side;
      for (int k = 1; k <= QW; k++) begin
        side_r[k] <= side_r[k-1];
      end
    end
  end

  bsp_back u_back (
    .clk   (clk),
    .en    (en && !ovf_f_unused | en),
    .scr_w (scr_w_r),
    .scr_h (scr_h_r),
    .quo   (quo),
    .side  (side_r[QW]),
    .res   (out_data)
  );

endmodule

@@ tb/tb.sv @@
// self-checking testbench for billboard_sprite_projection_unit
// depends on bsp_pkg and the rtl of the block; a scoreboard class predicts each
// result from the accepted sprite beat and the screen registers
module tb;
  timeunit 1ns;
  timeprecision 1ps;
  import bsp_pkg::*;

  localparam int LIMIT = 600000;
  localparam int DRAIN = 40;

  class proj_scoreboard;
    bsp_out_t pending[$];
    longint scr_w = 640;
    longint scr_h = 480;
    int errors = 0;

    function void set_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
      if (idx == REG_SCREEN_WIDTH) scr_w = val;
      else if (idx == REG_SCREEN_HEIGHT) scr_h = val;
    endfunction

    function longint sat(longint v, longint lo, longint hi);
      return v < lo ? lo : (v > hi ? hi : v);
    endfunction

    function longint mag(longint v);
      return v < 0 ? -v : v;
    endfunction

    function void note(bsp_in_t b);
      longint dx, dy, det, tx, ty, dep, center, full, size, bottom, top, left, right;
      bsp_out_t r;
      dx = longint'(b.sprite_pos_x) - longint'(b.viewer_x);
      dy = longint'(b.viewer_y) - longint'(b.sprite_pos_y);
      det = longint'(b.view_plane_x) * b.look_y - longint'(b.look_x) * b.view_plane_y;
      tx = longint'(b.look_y) * dx - longint'(b.look_x) * dy;
      ty = longint'(b.view_plane_x) * dy - longint'(b.view_plane_y) * dx;
      dep = (det != 0) ? (ty * 262144) / det : 0;
      dep = sat(dep, -8388608, 8388607);
      r = '0;
      r.in_front = (det != 0) && (dep > 0);
      r.depth = dep[23:0];
      if (r.in_front) begin
        center = sat(((scr_w / 2) * (ty - tx)) / ty, -32768, 32767);
        full = (scr_h * mag(det)) / (mag(ty) * 64);
        size = (full * longint'(b.sprite_scale)) / 256;
        bottom = scr_h / 2 + full / 2;
        top = bottom - size;
        if (top < 0) top = 0;
        if (bottom >= scr_h) bottom = scr_h - 1;
        left = center - size / 2;
        if (left < 0) left = 0;
        right = center + size / 2;
        if (right >= scr_w) right = scr_w - 1;
        r.center_column = center[15:0];
        r.scaled_height = 15'(sat(size, 0, 32767));
        r.scaled_width = 15'(sat(size, 0, 32767));
        r.first_column = 15'(sat(left, 0, 32767));
        r.end_column = 16'(sat(right, -32768, 32767));
        r.first_row = 15'(sat(top, 0, 32767));
        r.end_row = 12'(sat(bottom, 0, 4095));
      end
      pending.push_back(r);
    endfunction

    function void cmp(string name, longint e, longint a);
      if (e != a) begin
        errors++;
        $display("%0t %s mismatch: expected %0d actual %0d", $time, name, e, a);
      end
    endfunction

    function void check(bsp_out_t got);
      bsp_out_t e;
      if (pending.size() == 0) begin
        errors++;
        $display("%0t unexpected result beat: expected none actual %h", $time, got);
        return;
      end
      e = pending.pop_front();
      cmp("in_front", e.in_front, got.in_front);
      cmp("depth", e.depth, got.depth);
      cmp("center_column", e.center_column, got.center_column);
      cmp("scaled_height", e.scaled_height, got.scaled_height);
      cmp("scaled_width", e.scaled_width, got.scaled_width);
      cmp("first_column", e.first_column, got.first_column);
      cmp("end_column", e.end_column, got.end_column);
      cmp("first_row", e.first_row, got.first_row);
      cmp("end_row", e.end_row, got.end_row);
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  bsp_in_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  bsp_out_t out_data;
  logic cfg_we = 0;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [CFG_W-1:0] cfg_data = '0;

  proj_scoreboard sb = new();
  int cycles = 0;
  bit calm = 0;

  billboard_sprite_projection_unit uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data)
  );

  always #6 clk = ~clk;

  always @(posedge clk) begin
    cycles++;
    if (cycles > LIMIT) begin
      $display("tb: FAIL");
      $finish;
    end
  end

  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check(out_data);
  end

  // result side back-pressure
  initial begin
    int n;
    forever begin
      n = calm ? 0 : $urandom_range(0, 10);
      repeat (n) begin
        @(negedge clk);
        out_stall <= 1;
      end
      @(negedge clk);
      out_stall <= 0;
      @(posedge clk);
      while (!(rst_n && out_valid)) @(posedge clk);
    end
  end

  task automatic send_sprite(bsp_in_t b);
    int n;
    n = calm ? 0 : $urandom_range(0, 10);
    repeat (n) begin
      @(negedge clk);
      in_valid <= 0;
      @(posedge clk);
    end
    @(negedge clk);
    in_valid <= 1;
    in_data <= b;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    sb.note(b);
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] val);
    @(negedge clk);
    in_valid <= 0;
    cfg_we <= 1;
    cfg_index <= idx;
    cfg_data <= val;
    @(negedge clk);
    cfg_we <= 0;
    sb.set_reg(idx, val);
  endtask

  task automatic drain();
    @(negedge clk);
    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (DRAIN) @(posedge clk);
  endtask

  function automatic bsp_in_t noise_sprite();
    bsp_in_t b;
    b.sprite_pos_x = 16'($urandom);
    b.sprite_pos_y = 16'($urandom);
    b.sprite_scale = 12'($urandom);
    b.viewer_x = 16'($urandom);
    b.viewer_y = 16'($urandom);
    b.look_x = 16'($urandom);
    b.look_y = 16'($urandom);
    b.view_plane_x = 16'($urandom);
    b.view_plane_y = 16'($urandom);
    return b;
  endfunction

  // camera with plane perpendicular to direction, sprite near the viewer
  function automatic bsp_in_t scene_sprite();
    bsp_in_t b;
    int lx, ly, k, span;
    lx = int'($urandom_range(0, 32768)) - 16384;
    ly = int'($urandom_range(0, 32768)) - 16384;
    k = $urandom_range(1, 3);
    span = ($urandom_range(0, 3) == 0) ? 16000 : 2048;
    b.look_x = 16'(lx);
    b.look_y = 16'(ly);
    b.view_plane_x = 16'((ly * 2) / (k + 1));
    b.view_plane_y = 16'(-(lx * 2) / (k + 1));
    b.viewer_x = 16'(int'($urandom_range(0, 32000)) - 16000);
    b.viewer_y = 16'(int'($urandom_range(0, 32000)) - 16000);
    b.sprite_pos_x = 16'(int'(b.viewer_x) + int'($urandom_range(0, 2 * span)) - span);
    b.sprite_pos_y = 16'(int'(b.viewer_y) + int'($urandom_range(0, 2 * span)) - span);
    b.sprite_scale = ($urandom_range(0, 1) == 0) ? 12'd256 : 12'($urandom);
    return b;
  endfunction

  task automatic random_phase(int count);
    repeat (count) begin
      if ($urandom_range(0, 19) == 0) calm = ~calm;
      send_sprite(($urandom_range(0, 9) < 7) ? scene_sprite() : noise_sprite());
    end
    calm = 0;
    drain();
  endtask

  initial begin
    bsp_in_t b;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1;
    repeat (4) @(posedge clk);

    // directed beats at the default screen size
    b = '0;
    send_sprite(b);
    b = '1;
    send_sprite(b);
    b = {1'b1, 139'b0};
    b.sprite_pos_x = 16'sh8000; b.sprite_pos_y = 16'sh8000; b.viewer_x = 16'sh7fff;
    b.viewer_y = 16'sh7fff; b.look_x = 16'sh8000; b.look_y = 16'sh8000;
    b.view_plane_x = 16'sh7fff; b.view_plane_y = 16'sh8000; b.sprite_scale = 12'hfff;
    send_sprite(b);
    b = '0;
    b.look_y = 16'sd16384; b.view_plane_x = 16'sd10923; b.sprite_pos_y = -16'sd512;
    b.sprite_scale = 12'd256;
    send_sprite(b);
    b.sprite_pos_y = 16'sd512;
    send_sprite(b);
    b.sprite_pos_y = -16'sd1; b.sprite_scale = 12'd0;
    send_sprite(b);
    b.look_y = 16'sh7fff; b.view_plane_x = 16'sh7fff; b.sprite_pos_y = -16'sd1;
    b.sprite_pos_x = 16'sd1; b.sprite_scale = 12'hfff;
    send_sprite(b);
    b.look_x = 16'sd4096; b.look_y = 16'sd8192; b.view_plane_x = 16'sd8192;
    b.view_plane_y = 16'sd16384;
    send_sprite(b);
    b = '0;
    b.look_y = 16'sd16384; b.view_plane_x = 16'sd10923; b.sprite_pos_y = -16'sd32768;
    b.viewer_y = 16'sd32767; b.sprite_pos_x = 16'sd32767; b.viewer_x = -16'sd32768;
    b.sprite_scale = 12'hfff;
    send_sprite(b);
    b.sprite_pos_x = 16'sd0; b.viewer_x = 16'sd0; b.sprite_pos_y = -16'sd32768;
    b.viewer_y = 16'sd32767;
    send_sprite(b);
    b.look_y = -16'sd16384; b.view_plane_x = -16'sd10923; b.sprite_pos_y = 16'sd256;
    b.viewer_y = 16'sd0; b.sprite_pos_x = 16'sd3000;
    send_sprite(b);
    drain();

    write_reg(REG_SCREEN_WIDTH, 13'd0);
    write_reg(REG_SCREEN_HEIGHT, 13'd0);
    random_phase(150);
    write_reg(REG_SCREEN_WIDTH, 13'd8191);
    write_reg(REG_SCREEN_HEIGHT, 13'd8191);
    random_phase(250);
    write_reg(REG_SCREEN_WIDTH, 13'd1);
    write_reg(REG_SCREEN_HEIGHT, 13'd1);
    random_phase(150);
    write_reg(REG_SCREEN_WIDTH, 13'd4096);
    write_reg(REG_SCREEN_HEIGHT, 13'd4096);
    write_reg(2'd2, 13'd5);
    write_reg(2'd3, 13'h1fff);
    random_phase(250);
    write_reg(REG_SCREEN_WIDTH, 13'd640);
    write_reg(REG_SCREEN_HEIGHT, 13'd480);
    random_phase(250);
    write_reg(REG_SCREEN_WIDTH, 13'($urandom_range(2, 8190)));
    write_reg(REG_SCREEN_HEIGHT, 13'($urandom_range(2, 8190)));
    random_phase(290);

    if (sb.errors == 0 && sb.pending.size() == 0) begin
      $display("tb: PASS");
    end else begin
      $display("tb: FAIL");
    end
    $finish;
  end
endmodule
